// File: src/abd_pkg.sv
// shared types, constants and channel arithmetic for the argb box downscaler
// no dependencies
package abd_pkg;

    localparam int PIX_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int CHAN_W     = 14;
    localparam int NUM_CHAN   = 4;
    localparam int SUM_W      = NUM_CHAN * CHAN_W;
    localparam int SIZE_W     = 13;
    localparam int ROW_W      = 12;
    localparam int HEIGHT_MAX = 4096;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int SHIFT_W    = 2;
    localparam int SUB_W      = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd3;

    // classification of one queued pixel
    typedef struct packed {
        logic                first_blk;  // first pixel of its block
        logic                seg_start;  // first pixel of a block row segment
        logic                seg_end;    // last pixel of a segment, sums go to memory
        logic                emit;       // last pixel of the block, result follows
        logic                last;       // result is the frame's last
        logic [SHIFT_W-1:0]  shift;
    } abd_ctl_t;

    function automatic logic [SUM_W-1:0] add_pixel(input logic [SUM_W-1:0] sums,
                                                   input logic [PIX_W-1:0] px);
        logic [SUM_W-1:0] r;
        r = '0;
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            r[ch*CHAN_W +: CHAN_W] = sums[ch*CHAN_W +: CHAN_W]
                                   + CHAN_W'(px[ch*BYTE_W +: BYTE_W]);
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] average(input logic [SUM_W-1:0] sums,
                                                 input logic [SHIFT_W-1:0] shift);
        logic [PIX_W-1:0] r;
        r = '0;
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            r[ch*BYTE_W +: BYTE_W] = BYTE_W'(sums[ch*CHAN_W +: CHAN_W] >> {shift, 1'b0});
        end
        return r;
    endfunction

endpackage

// File: src/abd_if.sv
// channel interfaces: pixel stream, result stream and configuration writes
// depends on abd_pkg
interface abd_pix_if;
    logic                        valid;
    logic                        ready;
    logic [abd_pkg::PIX_W-1:0]   pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

interface abd_out_if;
    logic                        valid;
    logic                        ready;
    logic [abd_pkg::PIX_W-1:0]   pixel_out;
    logic                        frame_done;

    modport source (output valid, output pixel_out, output frame_done, input ready);
    modport sink (input valid, input pixel_out, input frame_done, output ready);
endinterface

interface abd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [abd_pkg::CFG_IDX_W-1:0]    index;
    logic [abd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/abd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module abd_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/abd_fifo.sv
// short queue between the classifying front and the accumulating back
// no dependencies
module abd_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

endmodule

// File: src/abd_front.sv
// front: configuration registers, raster position and pixel classification
// depends on abd_pkg and abd_if
module abd_front #(
    parameter int MAX_WIDTH = 4096,
    localparam int COL_W  = $clog2(MAX_WIDTH),
    localparam int W_W    = COL_W + 1,
    localparam int ADDR_W = $clog2(MAX_WIDTH / 2)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    abd_cfg_if.sink                   cfg,
    abd_pix_if.sink                   pix,
    input  logic                      full,
    output logic                      push,
    output logic [abd_pkg::PIX_W-1:0] item_pixel,
    output logic [ADDR_W-1:0]         item_bx,
    output abd_pkg::abd_ctl_t         item_ctl
);

    localparam int SW = abd_pkg::SIZE_W;
    localparam int SUBW = abd_pkg::SUB_W;

    logic [SW-1:0]                width_reg;
    logic [SW-1:0]                height_reg;
    logic [abd_pkg::SHIFT_W-1:0]  shift_reg;
    logic                         alpha_reg;
    logic [COL_W-1:0]             col_reg, col_next;
    logic [abd_pkg::ROW_W-1:0]    row_reg, row_next;

    logic                         cfg_wr;
    logic                         accept;
    logic [W_W-1:0]               w_eff;
    logic [SW-1:0]                h_eff;
    logic [W_W-1:0]               ow;
    logic [SW-1:0]                oh;
    logic [COL_W-1:0]             bx;
    logic [abd_pkg::ROW_W-1:0]    by;
    logic [SUBW-1:0]              mask;
    logic [SUBW-1:0]              cx;
    logic [SUBW-1:0]              cy;
    logic                         col_last;
    logic                         row_last;
    logic                         in_range;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign pix.ready = !full;
    assign accept    = pix.valid && pix.ready;

    // sizes clamped to what the position counters can hold
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = W_W'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = W_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = W_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = SW'(1);
        end
        else if (height_reg > SW'(abd_pkg::HEIGHT_MAX))
        begin
            h_eff = SW'(abd_pkg::HEIGHT_MAX);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign ow       = w_eff >> shift_reg;
    assign oh       = h_eff >> shift_reg;
    assign bx       = col_reg >> shift_reg;
    assign by       = row_reg >> shift_reg;
    assign mask     = SUBW'((4'd1 << shift_reg) - 4'd1);
    assign cx       = col_reg[SUBW-1:0] & mask;
    assign cy       = row_reg[SUBW-1:0] & mask;
    assign col_last = (W_W'(col_reg) == w_eff - 1'b1);
    assign row_last = (SW'(row_reg) == h_eff - 1'b1);
    assign in_range = (W_W'(bx) < ow) && (SW'(by) < oh);

    assign push       = accept && in_range;
    assign item_bx    = ADDR_W'(bx);
    assign item_pixel = alpha_reg ? {abd_pkg::NUM_CHAN{pix.pixel_in[31:24]}} : pix.pixel_in;

    always_comb
    begin
        item_ctl.first_blk = (cx == '0) && (cy == '0);
        item_ctl.seg_start = (cx == '0);
        item_ctl.seg_end   = (shift_reg != '0) && (cx == mask);
        item_ctl.emit      = (cx == mask) && (cy == mask);
        item_ctl.shift     = shift_reg;
        if (shift_reg == '0)
        begin
            item_ctl.last = col_last && row_last;
        end
        else
        begin
            item_ctl.last = (W_W'(bx) == ow - 1'b1) && (SW'(by) == oh - 1'b1);
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SW'(256);
            height_reg <= SW'(256);
            shift_reg  <= '0;
            alpha_reg  <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_wr)
            begin
                case (cfg.index)
                    abd_pkg::REG_WIDTH:  width_reg  <= cfg.data;
                    abd_pkg::REG_HEIGHT: height_reg <= cfg.data;
                    abd_pkg::REG_SHIFT:  shift_reg  <= cfg.data[abd_pkg::SHIFT_W-1:0];
                    abd_pkg::REG_ALPHA:  alpha_reg  <= cfg.data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: src/abd_back.sv
// back: per-column sum read-modify-write, running segment sum, result register
// depends on abd_pkg and abd_if
module abd_back #(
    parameter int ADDR_W = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      empty,
    input  logic [abd_pkg::PIX_W-1:0] head_pixel,
    input  logic [ADDR_W-1:0]         head_bx,
    input  abd_pkg::abd_ctl_t         head_ctl,
    output logic                      pop,
    output logic                      ram_we,
    output logic [ADDR_W-1:0]         ram_waddr,
    output logic [abd_pkg::SUM_W-1:0] ram_wdata,
    output logic                      ram_re,
    output logic [ADDR_W-1:0]         ram_raddr,
    input  logic [abd_pkg::SUM_W-1:0] ram_rdata,
    abd_out_if.source                 res
);

    logic                       go;
    logic                       r1_valid_reg;
    logic [abd_pkg::PIX_W-1:0]  r1_pixel_reg;
    logic [ADDR_W-1:0]          r1_bx_reg;
    abd_pkg::abd_ctl_t          r1_ctl_reg;
    logic                       hit_reg;
    logic [abd_pkg::SUM_W-1:0]  acc_reg;
    logic                       out_valid_reg;
    logic [abd_pkg::PIX_W-1:0]  out_pixel_reg;
    logic                       out_last_reg;
    logic [abd_pkg::SUM_W-1:0]  base;
    logic [abd_pkg::SUM_W-1:0]  sum;

    // the whole back advances together whenever the result register can take a value
    assign go  = !out_valid_reg || res.ready;
    assign pop = go && !empty;

    assign ram_re    = pop;
    assign ram_raddr = head_bx;
    assign ram_we    = go && r1_valid_reg && r1_ctl_reg.seg_end;
    assign ram_waddr = r1_bx_reg;
    assign ram_wdata = sum;

    // a read that saw the same-edge write takes the fresh sum, still held in acc_reg
    always_comb
    begin
        if (r1_ctl_reg.first_blk)
        begin
            base = '0;
        end
        else if (r1_ctl_reg.seg_start)
        begin
            base = hit_reg ? acc_reg : ram_rdata;
        end
        else
        begin
            base = acc_reg;
        end
    end

    assign sum = abd_pkg::add_pixel(base, r1_pixel_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            r1_valid_reg  <= !empty;
            out_valid_reg <= r1_valid_reg && r1_ctl_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            r1_pixel_reg <= head_pixel;
            r1_bx_reg    <= head_bx;
            r1_ctl_reg   <= head_ctl;
            hit_reg      <= ram_we && (ram_waddr == head_bx);
        end
        if (go && r1_valid_reg)
        begin
            acc_reg <= sum;
            if (r1_ctl_reg.emit)
            begin
                out_pixel_reg <= abd_pkg::average(sum, r1_ctl_reg.shift);
                out_last_reg  <= r1_ctl_reg.last;
            end
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.pixel_out  = out_pixel_reg;
    assign res.frame_done = out_last_reg;

endmodule

// File: src/argb_box_downscale_core.sv
// argb box downscaler: pixels pass the queue, the back's pixel register and the result register
// throughput one pixel per cycle while the queue is not full, set by the single-add
//   accumulate and the one read plus one write port of the column sum memory
// reset: 256 x 256 frame, copy mode, alpha view off, position zero, queue and result empty
// the column sum memory is not cleared; each entry is written by its block's first pixel row
module argb_box_downscale_core #(
    parameter int MAX_WIDTH   = 4096,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    abd_cfg_if.sink   cfg,
    abd_pix_if.sink   pixel_stream,
    abd_out_if.source result_stream
);

    // one column sum entry per block column at the smallest block size
    localparam int ADDR_W  = $clog2(MAX_WIDTH / 2);
    localparam int CTL_W   = $bits(abd_pkg::abd_ctl_t);
    localparam int ITEM_W  = abd_pkg::PIX_W + ADDR_W + CTL_W;

    // front to queue
    logic                       push;
    logic                       full;
    logic [abd_pkg::PIX_W-1:0]  item_pixel;
    logic [ADDR_W-1:0]          item_bx;
    abd_pkg::abd_ctl_t          item_ctl;

    // queue to back
    logic                       pop;
    logic                       empty;
    logic [ITEM_W-1:0]          head;
    logic [abd_pkg::PIX_W-1:0]  head_pixel;
    logic [ADDR_W-1:0]          head_bx;
    abd_pkg::abd_ctl_t          head_ctl;

    // column sum memory
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [abd_pkg::SUM_W-1:0]  ram_wdata;
    logic                       ram_re;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [abd_pkg::SUM_W-1:0]  ram_rdata;

    // front: takes every pixel transfer, tracks the raster position and drops
    // pixels of partial edge blocks; only whole-block pixels are queued
    abd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pix        (pixel_stream),
        .full       (full),
        .push       (push),
        .item_pixel (item_pixel),
        .item_bx    (item_bx),
        .item_ctl   (item_ctl)
    );

    // queue lets the front keep taking pixels while a result waits downstream
    abd_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({item_pixel, item_bx, item_ctl}),
        .full  (full),
        .pop   (pop),
        .rdata (head),
        .empty (empty)
    );

    assign head_pixel = head[ITEM_W-1 -: abd_pkg::PIX_W];
    assign head_bx    = head[CTL_W +: ADDR_W];
    assign head_ctl   = abd_pkg::abd_ctl_t'(head[CTL_W-1:0]);

    // back: reads the column sum as a pixel leaves the queue, adds the pixel once it
    // is registered and writes the sum back at the end of each block row segment
    abd_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head_pixel (head_pixel),
        .head_bx    (head_bx),
        .head_ctl   (head_ctl),
        .pop        (pop),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .res        (result_stream)
    );

    abd_ram #(
        .WIDTH (abd_pkg::SUM_W),
        .DEPTH (MAX_WIDTH / 2)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a read colliding with the write of the same column always comes from the
    // first pixel of a segment: the next row of the block or the next block row
    a_collide_is_segment_start : assert property (
        @(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re && (ram_waddr == ram_raddr))
            |-> head_ctl.seg_start
    ) else $error("same-edge column read is not a segment start");

    // the queue never takes a transfer while full nor gives one while empty
    a_queue_bounds : assert property (
        @(posedge clk) disable iff (!rst_n)
        (!(push && full)) && (!(pop && empty))
    ) else $error("queue overflow or underflow");

    // a waiting result holds its value until it is taken
    a_result_held : assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_stream.valid && !result_stream.ready)
            |=> (result_stream.valid && $stable(result_stream.pixel_out)
                 && $stable(result_stream.frame_done))
    ) else $error("waiting result changed");

endmodule
